// ===== rtl/psg_pkg.sv =====
// Shared types, register map and level table for the sound generator.
package psg_pkg;

  localparam int NUM_REGS = 14;

  // Register map of the generator's byte registers.
  localparam logic [3:0] REG_NOISE_PER = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_VOL_A     = 4'd8;
  localparam logic [3:0] REG_ENV_LO    = 4'd11;
  localparam logic [3:0] REG_ENV_HI    = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE = 4'd13;
  localparam logic [3:0] REG_LIMIT     = 4'd14;

  // Configuration register indexes.
  localparam logic CFG_EMU_ENABLE = 1'b0;
  localparam logic CFG_TURBO      = 1'b1;

  // Envelope mode bits.
  localparam logic [2:0] ENV_MODE_IDLE    = 3'd0;
  localparam logic [2:0] ENV_MODE_PENDING = 3'd2;
  localparam logic [2:0] ENV_MODE_DOWN    = 3'd4;
  localparam logic [2:0] ENV_MODE_UP      = 3'd5;

  // The feedback taps reach one bit above the 17-bit shift register.
  localparam logic [17:0] LFSR_TAPS  = 18'h24000;
  localparam logic [16:0] LFSR_SEED  = 17'h00001;
  localparam logic [11:0] TONE_MIN   = 12'd6;
  localparam logic [15:0] TICK_STATES = 16'd16;

  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  step;
    logic [15:0] count;
  } env_state_t;

  // Logarithmic volume table.
  function automatic logic [7:0] vol_lut(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'h00;
      4'd1:    v = 8'h03;
      4'd2:    v = 8'h05;
      4'd3:    v = 8'h07;
      4'd4:    v = 8'h0A;
      4'd5:    v = 8'h0F;
      4'd6:    v = 8'h15;
      4'd7:    v = 8'h23;
      4'd8:    v = 8'h2B;
      4'd9:    v = 8'h43;
      4'd10:   v = 8'h5A;
      4'd11:   v = 8'h73;
      4'd12:   v = 8'h92;
      4'd13:   v = 8'hAF;
      4'd14:   v = 8'hD9;
      default: v = 8'hFF;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/psg_env.sv =====
// Envelope generator: next state of the envelope for one tick.
module psg_env import psg_pkg::*; (
  input  env_state_t  cur,
  input  logic [15:0] period,
  input  logic [3:0]  shape,
  output env_state_t  nxt
);

  logic [15:0]       period_eff;
  logic [2:0]        mode;
  logic signed [5:0] step;

  always_comb begin
    period_eff = (period == 16'd0) ? 16'd1 : period;
    nxt  = cur;
    mode = cur.mode;
    step = $signed({1'b0, cur.step});
    if (cur.count < period_eff) begin
      nxt.count = cur.count + 16'd1;
    end else begin
      nxt.count = 16'd0;
      if (mode[1]) begin
        case (shape) inside
          4'd0, 4'd1, 4'd2, 4'd3, 4'd8, 4'd9, 4'd10, 4'd11: begin
            mode = ENV_MODE_DOWN;
            step = 6'sd16;
          end
          default: begin
            mode = ENV_MODE_UP;
            step = -6'sd1;
          end
        endcase
      end
      if (mode[2]) begin
        case (shape) inside
          4'd0, 4'd1, 4'd2, 4'd3, 4'd9: begin
            step = step - 6'sd1;
            if (step <= 6'sd0) begin
              step = 6'sd0;
              mode = ENV_MODE_IDLE;
            end
          end
          4'd4, 4'd5, 4'd6, 4'd7, 4'd15: begin
            step = step + 6'sd1;
            if (step >= 6'sd16) begin
              step = 6'sd0;
              mode = ENV_MODE_IDLE;
            end
          end
          4'd8: begin
            step = step - 6'sd1;
            if (step < 6'sd0) step = 6'sd15;
          end
          4'd10, 4'd14: begin
            step = mode[0] ? step + 6'sd1 : step - 6'sd1;
            if (step >= 6'sd16) begin
              step = 6'sd15;
              mode = ENV_MODE_DOWN;
            end
            if (step < 6'sd0) begin
              step = 6'sd0;
              mode = ENV_MODE_UP;
            end
          end
          4'd11: begin
            step = step - 6'sd1;
            if (step < 6'sd0) begin
              step = 6'sd15;
              mode = ENV_MODE_IDLE;
            end
          end
          4'd12: begin
            step = step + 6'sd1;
            if (step >= 6'sd16) step = 6'sd0;
          end
          default: begin
            step = step + 6'sd1;
            if (step >= 6'sd15) begin
              step = 6'sd15;
              mode = ENV_MODE_IDLE;
            end
          end
        endcase
      end
      nxt.mode = mode;
      nxt.step = step[4:0];
    end
  end

endmodule

// ===== rtl/psg_tone_noise_envelope.sv =====
// Top level of the three-channel tone, noise and envelope sound generator.
//
// Usage: each input word on the in_ channel is either a register write
// (in_kind = 1, in_reg_index / in_reg_value) or a report of elapsed CPU
// clock states (in_kind = 0, in_tstates). Clock states gather in a 16-bit
// saturating prescaler; when it holds more than 15, sixteen are taken off
// and the generator runs one tick. Each tick produces one output word on
// the out_ channel carrying the three channel levels. Register writes and
// time words that do not reach a tick produce no output word.
// The cfg_ port holds two one-bit controls: index 0 enables the generator,
// index 1 (turbo) freezes it. Write them only while the block is idle.
// Timing: a word is captured in an input register, then processed by the
// tone, noise and envelope logic straight into the output register once
// that register is free or draining, so out_valid rises only after the
// input register has held the word. One word is accepted every clock cycle
// while the output side keeps up; the input register and the output
// register together keep in_ready high while a result waits to be taken.
// When out_ready stays low, one finished word is held and one more word is
// parked in the input register before in_ready falls.
// Reset (rst_n low, synchronous) clears the byte registers, the prescaler and
// the counters, loads the noise shift register with one and enables
// the generator.
module psg_tone_noise_envelope import psg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [5:0] in_tstates,
  input  logic [3:0] in_reg_index,
  input  logic [7:0] in_reg_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_level_a,
  output logic [7:0] out_level_b,
  output logic [7:0] out_level_c,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata
);

  // Configuration.
  logic emu_en_r, turbo_r;

  // Input register.
  logic       s1_valid_r, s1_kind_r;
  logic [5:0] s1_tstates_r;
  logic [3:0] s1_idx_r;
  logic [7:0] s1_val_r;

  // Generator state.
  logic [7:0]  regs_r [NUM_REGS];
  logic [15:0] acc_r, acc_nxt;
  logic [11:0] tone_cnt_r [3];
  logic [11:0] tone_cnt_nxt [3];
  logic [2:0]  tone_out_r, tone_out_nxt;
  logic [4:0]  noise_cnt_r, noise_cnt_nxt;
  logic [4:0]  noise_per_r, noise_per_nxt;
  logic [16:0] lfsr_r, lfsr_nxt;
  logic [17:0] lfsr_x;
  logic        noise_out_r, noise_out_nxt;
  env_state_t  env_r, env_tick;

  // Output register.
  logic       out_valid_r;
  logic [7:0] level_r [3];
  logic [7:0] level_nxt [3];

  logic        s1_go, tick;
  logic [16:0] acc_sum;
  logic [15:0] acc_sat;
  logic [11:0] tone_per;
  logic        mix_t, mix_n;
  logic [7:0]  vol;

  // The input word advances when the output register is free or draining.
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  assign out_valid   = out_valid_r;
  assign out_level_a = level_r[0];
  assign out_level_b = level_r[1];
  assign out_level_c = level_r[2];

  // Prescaler: saturating add, then one tick once more than 15 states are in.
  assign acc_sum = {1'b0, acc_r} + {11'd0, s1_tstates_r};
  assign acc_sat = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
  assign tick    = !s1_kind_r && emu_en_r && !turbo_r && (acc_sat > 16'd15);

  always_comb begin
    acc_nxt = acc_r;
    if (!s1_kind_r && emu_en_r && !turbo_r) begin
      acc_nxt = tick ? acc_sat - TICK_STATES : acc_sat;
    end
  end

  psg_env u_env (
    .cur    (env_r),
    .period ({regs_r[REG_ENV_HI], regs_r[REG_ENV_LO]}),
    .shape  (regs_r[REG_ENV_SHAPE][3:0]),
    .nxt    (env_tick)
  );

  // Tone dividers: a period below six holds the output high.
  always_comb begin
    tone_per = '0;
    for (int ch = 0; ch < 3; ch++) begin
      tone_per         = {regs_r[4'(2*ch+1)][3:0], regs_r[4'(2*ch)]};
      tone_cnt_nxt[ch] = tone_cnt_r[ch];
      tone_out_nxt[ch] = tone_out_r[ch];
      if (tone_per < TONE_MIN) begin
        tone_out_nxt[ch] = 1'b1;
      end else if (tone_cnt_r[ch] < tone_per) begin
        tone_cnt_nxt[ch] = tone_cnt_r[ch] + 12'd1;
      end else begin
        tone_out_nxt[ch] = ~tone_out_r[ch];
        tone_cnt_nxt[ch] = 12'd0;
      end
    end
  end

  // Noise divider. The shift register steps and the period is re-latched
  // only when the divider wraps. The feedback is formed one bit wider, so
  // a set low bit lands in the top bit after the shift.
  always_comb begin
    noise_cnt_nxt = noise_cnt_r;
    noise_per_nxt = noise_per_r;
    lfsr_nxt      = lfsr_r;
    noise_out_nxt = noise_out_r;
    lfsr_x        = lfsr_r[0] ? ({1'b0, lfsr_r} ^ LFSR_TAPS) : {1'b0, lfsr_r};
    if (noise_cnt_r < noise_per_r) begin
      noise_cnt_nxt = noise_cnt_r + 5'd1;
    end else begin
      if (lfsr_r[1] ^ lfsr_r[0]) noise_out_nxt = ~noise_out_r;
      lfsr_nxt      = lfsr_x[17:1];
      noise_cnt_nxt = 5'd0;
      noise_per_nxt = (regs_r[REG_NOISE_PER][4:0] == 5'd0) ?
                      5'd1 : regs_r[REG_NOISE_PER][4:0];
    end
  end

  // Mixer: a channel sounds only where both its tone and noise gates pass.
  always_comb begin
    mix_t = 1'b0;
    mix_n = 1'b0;
    vol   = '0;
    for (int ch = 0; ch < 3; ch++) begin
      mix_t = tone_out_nxt[ch] | regs_r[REG_MIXER][ch];
      mix_n = noise_out_nxt | regs_r[REG_MIXER][ch+3];
      vol   = regs_r[REG_VOL_A + 4'(ch)];
      if (!(mix_t && mix_n)) begin
        level_nxt[ch] = 8'h00;
      end else if (vol[4]) begin
        level_nxt[ch] = vol_lut(env_tick.step[3:0]);
      end else begin
        level_nxt[ch] = vol_lut(vol[3:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emu_en_r    <= 1'b1;
      turbo_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      tone_out_r  <= '0;
      noise_cnt_r <= '0;
      noise_per_r <= '0;
      lfsr_r      <= LFSR_SEED;
      noise_out_r <= 1'b0;
      env_r       <= '{mode: ENV_MODE_IDLE, step: 5'd0, count: 16'd0};
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
      for (int i = 0; i < 3; i++) tone_cnt_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_EMU_ENABLE) emu_en_r <= cfg_wdata;
        if (cfg_index == CFG_TURBO)      turbo_r  <= cfg_wdata;
      end

      if (in_ready) s1_valid_r <= in_valid;

      if (s1_go) begin
        out_valid_r <= tick;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (s1_go) begin
        if (s1_kind_r) begin
          if (s1_idx_r < REG_LIMIT) regs_r[s1_idx_r] <= s1_val_r;
          if (s1_idx_r == REG_ENV_SHAPE) env_r.mode <= ENV_MODE_PENDING;
        end
        acc_r <= acc_nxt;
        if (tick) begin
          env_r       <= env_tick;
          tone_out_r  <= tone_out_nxt;
          noise_cnt_r <= noise_cnt_nxt;
          noise_per_r <= noise_per_nxt;
          lfsr_r      <= lfsr_nxt;
          noise_out_r <= noise_out_nxt;
          for (int i = 0; i < 3; i++) tone_cnt_r[i] <= tone_cnt_nxt[i];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_kind_r    <= in_kind;
      s1_tstates_r <= in_tstates;
      s1_idx_r     <= in_reg_index;
      s1_val_r     <= in_reg_value;
    end
    if (s1_go && tick) begin
      for (int i = 0; i < 3; i++) level_r[i] <= level_nxt[i];
    end
  end

  // The noise shift register can never lock up at zero.
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != 17'd0)
    else $error("noise shift register reached zero");

  // The stored envelope step always indexes the sixteen-entry table.
  a_env_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    env_r.step <= 5'd15)
    else $error("envelope step out of range");

  // The input side stalls only when both registers are full and blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked output");

  // A result is only produced by a time word that reaches a tick.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_kind_r) |=> !out_valid_r)
    else $error("register write produced a result");

endmodule

// ===== dv/psg_tone_noise_envelope_test.sv =====
// Self-checking testbench for the three-channel tone, noise and envelope sound generator.
module psg_tone_noise_envelope_test import psg_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Kinds of input word.
  localparam logic KIND_TIME  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Byte registers that the package leaves unnamed.
  localparam logic [3:0] REG_TONE_A_LO = 4'd0;
  localparam logic [3:0] REG_TONE_A_HI = 4'd1;
  localparam logic [3:0] REG_TONE_B_LO = 4'd2;
  localparam logic [3:0] REG_TONE_B_HI = 4'd3;
  localparam logic [3:0] REG_TONE_C_LO = 4'd4;
  localparam logic [3:0] REG_TONE_C_HI = 4'd5;
  localparam logic [3:0] REG_VOL_B     = 4'd9;
  localparam logic [3:0] REG_VOL_C     = 4'd10;
  localparam logic [3:0] REG_UNUSED    = 4'd15;

  // Envelope shapes that do not fall into the plain decay (0 to 3) or plain
  // attack (4 to 7) groups.
  localparam logic [3:0] SHAPE_SAW_DOWN    = 4'd8;
  localparam logic [3:0] SHAPE_DECAY_LOW   = 4'd9;
  localparam logic [3:0] SHAPE_TRI_DOWN    = 4'd10;
  localparam logic [3:0] SHAPE_DECAY_HIGH  = 4'd11;
  localparam logic [3:0] SHAPE_SAW_UP      = 4'd12;
  localparam logic [3:0] SHAPE_ATTACK_HIGH = 4'd13;
  localparam logic [3:0] SHAPE_TRI_UP      = 4'd14;
  localparam logic [3:0] SHAPE_ATTACK_LOW  = 4'd15;

  // The noise taps reach one bit above the 17-bit register, so the feedback
  // is formed one bit wider and shifted back down.
  localparam logic [17:0] NOISE_TAPS = 18'h24000;

  localparam logic [7:0] LEVEL_CURVE [16] = '{
    8'h00, 8'h03, 8'h05, 8'h07, 8'h0A, 8'h0F, 8'h15, 8'h23,
    8'h2B, 8'h43, 8'h5A, 8'h73, 8'h92, 8'hAF, 8'hD9, 8'hFF
  };

  localparam int RANDOM_ITEMS  = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 64;
  localparam int CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } levels_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_kind;
  logic [5:0] in_tstates;
  logic [3:0] in_reg_index;
  logic [7:0] in_reg_value;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_level_a;
  logic [7:0] out_level_b;
  logic [7:0] out_level_c;
  logic       cfg_we;
  logic       cfg_index;
  logic       cfg_wdata;

  psg_tone_noise_envelope dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_tstates   (in_tstates),
    .in_reg_index (in_reg_index),
    .in_reg_value (in_reg_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_level_a  (out_level_a),
    .out_level_b  (out_level_b),
    .out_level_c  (out_level_c),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Shadow copy of the generator, starting from its reset state.
  logic [7:0]  sh_regs [NUM_REGS] = '{default: 8'h00};
  logic [15:0] prescale   = 16'd0;
  logic [11:0] tone_cnt [3] = '{default: 12'd0};
  logic [2:0]  tone_hi    = 3'b000;
  logic [4:0]  noise_cnt  = 5'd0;
  logic [4:0]  noise_per  = 5'd0;
  logic [16:0] lfsr       = 17'd1;
  logic        noise_bit  = 1'b0;
  logic [15:0] env_cnt    = 16'd0;
  int          env_step   = 0;
  logic [2:0]  env_mode   = ENV_MODE_IDLE;
  logic        gen_enable = 1'b1;
  logic        gen_turbo  = 1'b0;

  // Levels that the generator owes, oldest first.
  levels_t levels_due [$];

  int  errors      = 0;
  int  words_taken = 0;
  int  cycle_count = 0;
  int  rx_hold_req = 0;
  bit  tx_idle     = 1'b1;
  bit  rx_idle     = 1'b1;

  // Advances the shadow generator by one accepted word. A register write only
  // lands in the register file (a shape write also re-arms the envelope); a time
  // word feeds the prescaler while the generator is enabled and not frozen and,
  // once sixteen states are there, runs one tick and queues its three levels.
  function automatic void apply_word(input logic is_write, input logic [5:0] ts,
                                     input logic [3:0] ri, input logic [7:0] rv);
    logic [15:0] env_per;
    logic [3:0]  shape;
    logic [11:0] tone_per;
    logic [16:0] lfsr_inc;
    logic [17:0] lfsr_wide;
    logic [7:0]  vol;
    logic        t_on;
    logic        n_on;
    logic [7:0]  lv [3];
    int          acc;
    if (is_write == KIND_WRITE) begin
      if (ri < REG_LIMIT) begin
        sh_regs[ri] = rv;
        if (ri == REG_ENV_SHAPE) env_mode = ENV_MODE_PENDING;
      end
      return;
    end
    if (!gen_enable || gen_turbo) return;
    acc = prescale + ts;
    if (acc > 16'hFFFF) acc = 16'hFFFF;
    if (acc < TICK_STATES) begin
      prescale = 16'(acc);
      return;
    end
    prescale = 16'(acc - TICK_STATES);

    // Envelope: a period of zero behaves as one. A pending start only takes
    // effect when the current period runs out.
    env_per = {sh_regs[REG_ENV_HI], sh_regs[REG_ENV_LO]};
    shape = sh_regs[REG_ENV_SHAPE][3:0];
    if (env_per == 16'd0) env_per = 16'd1;
    if (env_cnt < env_per) begin
      env_cnt++;
    end else begin
      env_cnt = 16'd0;
      if (env_mode[1]) begin
        if (!shape[2]) begin
          env_mode = ENV_MODE_DOWN;
          env_step = 16;
        end else begin
          env_mode = ENV_MODE_UP;
          env_step = -1;
        end
      end
      if (env_mode[2]) begin
        if (shape[3:2] == 2'b00 || shape == SHAPE_DECAY_LOW) begin
          env_step--;
          if (env_step <= 0) begin
            env_step = 0;
            env_mode = ENV_MODE_IDLE;
          end
        end else if (shape[3:2] == 2'b01 || shape == SHAPE_ATTACK_LOW) begin
          env_step++;
          if (env_step >= 16) begin
            env_step = 0;
            env_mode = ENV_MODE_IDLE;
          end
        end else begin
          case (shape)
            SHAPE_SAW_DOWN: begin
              env_step--;
              if (env_step < 0) env_step = 15;
            end
            SHAPE_TRI_DOWN, SHAPE_TRI_UP: begin
              if (env_mode[0]) env_step++;
              else env_step--;
              if (env_step >= 16) begin
                env_step = 15;
                env_mode = ENV_MODE_DOWN;
              end
              if (env_step < 0) begin
                env_step = 0;
                env_mode = ENV_MODE_UP;
              end
            end
            SHAPE_DECAY_HIGH: begin
              env_step--;
              if (env_step < 0) begin
                env_step = 15;
                env_mode = ENV_MODE_IDLE;
              end
            end
            SHAPE_SAW_UP: begin
              env_step++;
              if (env_step >= 16) env_step = 0;
            end
            default: begin
              // Attack, then hold at the top.
              env_step++;
              if (env_step >= 15) begin
                env_step = 15;
                env_mode = ENV_MODE_IDLE;
              end
            end
          endcase
        end
      end
    end

    // Tone dividers: a period below the minimum pins the output high.
    for (int ch = 0; ch < 3; ch++) begin
      tone_per = {sh_regs[REG_TONE_A_HI + 2 * ch][3:0], sh_regs[REG_TONE_A_LO + 2 * ch]};
      if (tone_per < TONE_MIN) begin
        tone_hi[ch] = 1'b1;
      end else if (tone_cnt[ch] < tone_per) begin
        tone_cnt[ch]++;
      end else begin
        tone_hi[ch] = ~tone_hi[ch];
        tone_cnt[ch] = 12'd0;
      end
    end

    // Noise divider: the period register is only sampled when it wraps.
    if (noise_cnt < noise_per) begin
      noise_cnt++;
    end else begin
      lfsr_inc = lfsr + 17'd1;
      if (lfsr_inc[1]) noise_bit = ~noise_bit;
      lfsr_wide = {1'b0, lfsr};
      if (lfsr[0]) lfsr_wide = lfsr_wide ^ NOISE_TAPS;
      lfsr = lfsr_wide[17:1];
      noise_cnt = 5'd0;
      noise_per = sh_regs[REG_NOISE_PER][4:0];
      if (noise_per == 5'd0) noise_per = 5'd1;
    end

    // Mixer: a set enable bit forces that source on for its channel.
    for (int ch = 0; ch < 3; ch++) begin
      vol = sh_regs[REG_VOL_A + ch];
      t_on = tone_hi[ch] | sh_regs[REG_MIXER][ch];
      n_on = noise_bit | sh_regs[REG_MIXER][ch + 3];
      if (!(t_on && n_on)) lv[ch] = 8'h00;
      else if (vol[4]) lv[ch] = LEVEL_CURVE[env_step[3:0]];
      else lv[ch] = LEVEL_CURVE[vol[3:0]];
    end
    levels_due.push_back({lv[0], lv[1], lv[2]});
  endfunction

  // Offers one word after a random gap and returns at the edge that accepts
  // it. Valid is left high so that a following word can go out back to back;
  // anything else that follows must first drop valid through wait_idle.
  task automatic send_word(input logic is_write, input logic [5:0] ts,
                           input logic [3:0] ri, input logic [7:0] rv);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= is_write;
    in_tstates   <= ts;
    in_reg_index <= ri;
    in_reg_value <= rv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_word(is_write, ts, ri, rv);
  endtask

  // Fields that the word's kind does not use still carry random values.
  task automatic send_time(input logic [5:0] ts);
    send_word(KIND_TIME, ts, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_write(input logic [3:0] ri, input logic [7:0] rv);
    send_word(KIND_WRITE, 6'($urandom_range(0, 63)), ri, rv);
  endtask

  // Stops offering words, waits for every owed word to come back and then
  // lets the pipeline run dry, since a word that makes no output may still be
  // inside the block.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_EMU_ENABLE) gen_enable = val;
    else gen_turbo = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Register values shaped so that periods stay short enough for tones,
  // noise and envelope to move within a few ticks; one write in eight is
  // left fully random.
  function automatic logic [7:0] shaped_value(input logic [3:0] ri);
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    case (ri)
      REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO: return 8'($urandom_range(0, 24));
      REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: return 8'($urandom_range(0, 15) << 4);
      REG_ENV_LO: return 8'($urandom_range(0, 3));
      REG_ENV_HI: return 8'h00;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Prescaler edges, ignored registers and the corner cases of every block.
  task automatic test_directed_cases();
    send_time(6'd0);
    send_time(6'd15);                    // one state short of a tick
    send_time(6'd1);                     // exactly sixteen states
    send_time(6'd63);
    send_write(REG_LIMIT, 8'hFF);        // writes above the file are dropped
    send_write(REG_UNUSED, 8'hFF);
    send_write(REG_MIXER, 8'h38);        // noise masked on every channel
    send_write(REG_VOL_A, 8'h0F);
    send_write(REG_VOL_B, 8'h1F);        // channel B follows the envelope
    send_write(REG_VOL_C, 8'hE5);        // bits above the volume are ignored
    send_write(REG_TONE_A_LO, 8'd6);     // shortest period that toggles
    send_write(REG_TONE_B_LO, 8'hFF);
    send_write(REG_TONE_B_HI, 8'hFF);    // longest period, top nibble dropped
    send_write(REG_TONE_C_LO, 8'd5);     // too short: tone held high
    send_write(REG_ENV_SHAPE, {4'h0, SHAPE_ATTACK_HIGH}); // zero envelope period
    send_write(REG_NOISE_PER, 8'h00);    // zero noise period
    repeat (4) send_time(6'd63);
    send_write(REG_MIXER, 8'h00);
    send_write(REG_NOISE_PER, 8'hFF);
    repeat (3) send_time(6'd32);
  endtask

  // Walks the two controls through every combination. Time words must be
  // swallowed while frozen, but register writes still land.
  task automatic test_frozen_generator();
    wait_idle();
    cfg_write(CFG_EMU_ENABLE, 1'b0);
    repeat (6) send_time(6'($urandom_range(16, 63)));
    send_write(REG_VOL_A, 8'h1E);
    send_write(REG_ENV_SHAPE, 8'h0A);
    wait_idle();
    cfg_write(CFG_TURBO, 1'b1);
    repeat (6) send_time(6'($urandom_range(0, 63)));
    wait_idle();
    cfg_write(CFG_EMU_ENABLE, 1'b1);
    repeat (6) send_time(6'($urandom_range(16, 63)));
    send_write(REG_MIXER, 8'h07);
    wait_idle();
    cfg_write(CFG_TURBO, 1'b0);
    repeat (10) send_time(6'($urandom_range(16, 63)));
  endtask

  // The sink stops taking words for a long stretch while ticks keep coming,
  // so the block fills and drops in_ready; later the source holds back until
  // everything has drained.
  task automatic test_backpressure();
    wait_idle();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    repeat (24) send_time(6'($urandom_range(16, 63)));
    rx_hold_req = HOLD_CYCLES;
    repeat (12) send_time(6'($urandom_range(16, 63)));
    wait_idle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (8) send_time(6'($urandom_range(0, 63)));
  endtask

  // Bursts of register programming followed by runs of time words. Idling
  // on either side is switched per burst so some bursts run flat out.
  task automatic test_random_programs();
    int         n_items;
    logic [3:0] ri;
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(0, 4)) begin
        ri = 4'($urandom_range(0, 15));
        send_write(ri, shaped_value(ri));
        if (ri < REG_LIMIT) n_items++;
      end
      repeat ($urandom_range(2, 12)) begin
        if ($urandom_range(0, 9) == 0) send_time(6'($urandom_range(0, 15)));
        else send_time(6'($urandom_range(16, 63)));
        n_items++;
      end
    end
  endtask

  // Result sink: after each word it takes it stays away for a random number
  // of cycles, and a hold-off request keeps it away for a whole stretch.
  initial begin : result_sink
    int gap_left;
    int hold_left;
    int taken_seen;
    gap_left   = 0;
    hold_left  = 0;
    taken_seen = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (taken_seen != words_taken) begin
        taken_seen = words_taken;
        gap_left = rx_idle ? $urandom_range(0, 7) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every word taken from the block is held against the oldest owed levels.
  always @(posedge clk) begin
    levels_t got;
    levels_t want;
    string   field_name [3];
    field_name = '{"level_a", "level_b", "level_c"};
    if (rst_n && out_valid && out_ready) begin
      words_taken++;
      got = {out_level_a, out_level_b, out_level_c};
      if (levels_due.size() == 0) begin
        $error("output word with nothing owed: a=%0h b=%0h c=%0h", got.a, got.b, got.c);
        errors++;
      end else begin
        want = levels_due.pop_front();
        for (int ch = 0; ch < 3; ch++) begin
          if (got[23 - 8 * ch -: 8] !== want[23 - 8 * ch -: 8]) begin
            $error("%s: expected %0h, got %0h", field_name[ch],
                   want[23 - 8 * ch -: 8], got[23 - 8 * ch -: 8]);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = KIND_TIME;
    in_tstates   = 6'd0;
    in_reg_index = 4'd0;
    in_reg_value = 8'd0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_EMU_ENABLE;
    cfg_wdata    = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_frozen_generator();
    test_backpressure();
    test_random_programs();
    wait_idle();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/psg_pkg.sv
rtl/psg_env.sv
rtl/psg_tone_noise_envelope.sv
dv/psg_tone_noise_envelope_test.sv
